// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the modules that check their own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CNAS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cnas assertion failed");
// Condition must never be true at a clock edge outside reset.
`define CNAS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cnas forbidden condition seen");
`else
`define CNAS_ASSERT(lbl, prop)
`define CNAS_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/cnas_pkg.sv =====
// ----------------------------------------------------------------------------
// cnas_pkg
// Types, codes and fixed-point helpers of the Crank-Nicolson advection block.
// ----------------------------------------------------------------------------
package cnas_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int POINT_W        = 6;
    localparam int DATA_W         = 32;
    localparam int STEP_W         = 16;
    localparam int NPTS_W         = 7;
    localparam int MIN_POINTS     = 3;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_RUN  = 1'b1
    } cnas_kind_t;

    typedef enum logic {
        CFG_QUARTER_COURANT = 1'b0,
        CFG_POINTS_IN_USE   = 1'b1
    } cnas_cfg_t;

    typedef struct packed {
        cnas_kind_t                 kind;
        logic [POINT_W-1:0]         point_index;
        logic signed [DATA_W-1:0]   sample_in;
        logic [STEP_W-1:0]          step_count;
    } cnas_item_t;

    typedef struct packed {
        logic [POINT_W-1:0]         point_out;
        logic signed [DATA_W-1:0]   sample_out;
        logic                       last;
    } cnas_result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_R_A, ST_R_B, ST_R_C, ST_R_D, ST_R_E,
        ST_FI_A, ST_FI_B, ST_F_A, ST_F_B, ST_F_C, ST_F_D, ST_F_E,
        ST_B_INIT, ST_B_A, ST_B_B, ST_B_C, ST_O_A, ST_O_B
    } cnas_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAP_NEXT, OP_CAP_DIFF, OP_MUL_DIFF, OP_WR_Q,
        OP_FWD_INIT, OP_FWD_MUL_C, OP_FWD_PIVOT, OP_FWD_NUM, OP_FWD_WR_C,
        OP_FWD_WR_D, OP_BK_INIT, OP_BK_MUL, OP_BK_WR, OP_OUT_EMIT
    } cnas_op_t;

    typedef struct packed {
        cnas_op_t               op;
        logic [POINT_W-1:0]     addr;
        logic                   last;
    } cnas_cmd_t;

    typedef struct packed {
        logic                   div_done;
        logic [POINT_W-1:0]     last_idx;
    } cnas_status_t;

    // Sign-extend a Q16.16 word to 64 bits.
    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Scale a Q32.32 product back to Q16.16, rounding half up.
    function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

endpackage

// ===== hdl/cnas_div.sv =====
// ----------------------------------------------------------------------------
// cnas_div
// Radix-2 restoring divider: (num * 2^16) / den, truncated toward zero and
// saturated. The denominator is positive; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cnas_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num,
    input  logic [31:0]         den,
    output logic                done,
    output logic signed [31:0]  quo
);

    localparam int DVD_W = 48;
    localparam int CNT_W = $clog2(DVD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [32:0]         rem_reg, rem_next;
    logic [31:0]         den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [32:0]         rem_sh;
    logic [33:0]         trial;
    logic [31:0]         num_mag;
    logic signed [63:0]  quo_signed;

    // Magnitude of the numerator.
    assign num_mag = num[31] ? (~num + 32'd1) : num;

    // One restoring step.
    assign rem_sh = {rem_reg[31:0], dvd_reg[DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {num_mag, 16'd0};
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[31];
        end else if (busy_reg) begin
            if (trial[33]) begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[32:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Apply the sign and saturate.
    assign quo_signed = neg_reg ? -$signed({16'd0, dvd_reg}) : $signed({16'd0, dvd_reg});
    assign quo  = cnas_pkg::sat32(quo_signed);
    assign done = done_reg;

endmodule

// ===== hdl/cnas_datapath.sv =====
// ----------------------------------------------------------------------------
// cnas_datapath
// Wave, sweep coefficient and sweep right-hand-side memories, configuration
// registers, the shared multiplier and the divider, driven by commands.
// ----------------------------------------------------------------------------
module cnas_datapath #(
    parameter int MAX_POINTS = cnas_pkg::MAX_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  cnas_pkg::cnas_item_t    item,
    input  logic                    wr_en,
    input  cnas_pkg::cnas_cfg_t     wr_index,
    input  logic [31:0]             wr_data,
    input  cnas_pkg::cnas_cmd_t     cmd,
    output cnas_pkg::cnas_status_t  stat,
    output logic                    strobe,
    output cnas_pkg::cnas_result_t  result
);

    localparam int AW = $clog2(MAX_POINTS);

    logic signed [31:0] wave_mem  [MAX_POINTS];
    logic signed [31:0] coeff_mem [MAX_POINTS];
    logic signed [31:0] rhs_mem   [MAX_POINTS];

    logic signed [31:0] qc_reg, qc_next;
    logic [AW-1:0]      last_idx_reg, last_idx_next;
    logic signed [31:0] rd_wave_reg, rd_coeff_reg, rd_rhs_reg;
    logic signed [31:0] wn_reg, diff_reg, wi_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] cp_reg, dp_reg, m_reg, num_reg, opd_reg, x_reg;
    logic               strobe_reg;
    cnas_pkg::cnas_result_t result_reg;

    logic [AW-1:0]      addr;
    logic [6:0]         npts;
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [31:0] diff_next, q_next, num_next, x_next, piv_sat, pivot_next;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quo;
    logic               load_ok;

    assign addr = cmd.addr[AW-1:0];

    // Configuration writes; the mesh size is clamped to the legal range.
    assign npts = wr_data[6:0];
    always_comb
    begin
        qc_next       = qc_reg;
        last_idx_next = last_idx_reg;
        if (wr_en) begin
            unique case (wr_index)
                cnas_pkg::CFG_QUARTER_COURANT: qc_next = wr_data;
                cnas_pkg::CFG_POINTS_IN_USE:
                begin
                    if (npts < 7'(cnas_pkg::MIN_POINTS)) begin
                        last_idx_next = AW'(cnas_pkg::MIN_POINTS - 1);
                    end else if (npts > 7'(MAX_POINTS)) begin
                        last_idx_next = AW'(MAX_POINTS - 1);
                    end else begin
                        last_idx_next = AW'(npts - 7'd1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qc_reg       <= '0;
            last_idx_reg <= AW'(MAX_POINTS - 1);
            strobe_reg   <= 1'b0;
        end else begin
            qc_reg       <= qc_next;
            last_idx_reg <= last_idx_next;
            strobe_reg   <= (cmd.op == cnas_pkg::OP_OUT_EMIT);
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = qc_reg;
        mul_b  = diff_reg;
        unique case (cmd.op)
            cnas_pkg::OP_MUL_DIFF:  mul_b = diff_reg;
            cnas_pkg::OP_FWD_MUL_C: mul_b = cp_reg;
            cnas_pkg::OP_FWD_PIVOT: mul_b = dp_reg;
            cnas_pkg::OP_BK_MUL:
            begin
                mul_a = rd_coeff_reg;
                mul_b = x_reg;
            end
            default: mul_en = 1'b0;
        endcase
    end
    assign prod_next = cnas_pkg::sx64(mul_a) * cnas_pkg::sx64(mul_b);

    // Arithmetic that finishes each operation.
    assign diff_next = cnas_pkg::sat32(cnas_pkg::sx64(wn_reg) - cnas_pkg::sx64(rd_wave_reg));
    assign q_next    = cnas_pkg::sat32(cnas_pkg::sx64(wi_reg) - cnas_pkg::rnd_q16(prod_reg));
    assign piv_sat   = cnas_pkg::sat32(cnas_pkg::ONE_Q16 + cnas_pkg::rnd_q16(prod_reg));
    assign pivot_next = (piv_sat < 32'sh00010000) ? 32'sh00010000 : piv_sat;
    assign num_next  = cnas_pkg::sat32(cnas_pkg::sx64(opd_reg) + cnas_pkg::rnd_q16(prod_reg));
    assign x_next    = cnas_pkg::sat32(cnas_pkg::sx64(opd_reg) - cnas_pkg::rnd_q16(prod_reg));

    // Divider launches: first c / m, then the numerator over the same pivot.
    assign div_start = (cmd.op == cnas_pkg::OP_FWD_NUM) ||
                       (cmd.op == cnas_pkg::OP_FWD_WR_C && div_done);
    assign div_num   = (cmd.op == cnas_pkg::OP_FWD_NUM) ? qc_reg : num_reg;

    cnas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (m_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign load_ok = load && (7'(item.point_index) < 7'(MAX_POINTS));

    // Memories: registered reads at the command address.
    always_ff @(posedge clk)
    begin
        rd_wave_reg  <= wave_mem[addr];
        rd_coeff_reg <= coeff_mem[addr];
        rd_rhs_reg   <= rhs_mem[addr];
        if (load_ok) begin
            wave_mem[item.point_index[AW-1:0]] <= item.sample_in;
        end else if (cmd.op == cnas_pkg::OP_BK_INIT) begin
            wave_mem[addr] <= dp_reg;
        end else if (cmd.op == cnas_pkg::OP_BK_WR) begin
            wave_mem[addr] <= x_next;
        end
        if (cmd.op == cnas_pkg::OP_FWD_INIT) begin
            coeff_mem[addr] <= qc_reg;
        end else if (cmd.op == cnas_pkg::OP_FWD_WR_C && div_done) begin
            coeff_mem[addr] <= div_quo;
        end
        if (cmd.op == cnas_pkg::OP_WR_Q) begin
            rhs_mem[addr] <= q_next;
        end else if (cmd.op == cnas_pkg::OP_FWD_WR_D && div_done) begin
            rhs_mem[addr] <= div_quo;
        end
    end

    // Working registers of the three sweeps.
    always_ff @(posedge clk)
    begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
        unique case (cmd.op)
            cnas_pkg::OP_CAP_NEXT: wn_reg <= rd_wave_reg;
            cnas_pkg::OP_CAP_DIFF: diff_reg <= diff_next;
            cnas_pkg::OP_MUL_DIFF: wi_reg <= rd_wave_reg;
            cnas_pkg::OP_FWD_INIT:
            begin
                dp_reg <= rd_rhs_reg;
                cp_reg <= qc_reg;
            end
            cnas_pkg::OP_FWD_PIVOT:
            begin
                m_reg   <= pivot_next;
                opd_reg <= rd_rhs_reg;
            end
            cnas_pkg::OP_FWD_NUM: num_reg <= num_next;
            cnas_pkg::OP_FWD_WR_C:
            begin
                if (div_done) begin
                    cp_reg <= div_quo;
                end
            end
            cnas_pkg::OP_FWD_WR_D:
            begin
                if (div_done) begin
                    dp_reg <= div_quo;
                end
            end
            cnas_pkg::OP_BK_INIT: x_reg <= dp_reg;
            cnas_pkg::OP_BK_MUL: opd_reg <= rd_rhs_reg;
            cnas_pkg::OP_BK_WR: x_reg <= x_next;
            cnas_pkg::OP_OUT_EMIT:
            begin
                result_reg.point_out  <= cmd.addr;
                result_reg.sample_out <= rd_wave_reg;
                result_reg.last       <= cmd.last;
            end
            default: ;
        endcase
    end

    assign stat.div_done = div_done;
    assign stat.last_idx = cnas_pkg::POINT_W'(last_idx_reg);
    assign strobe        = strobe_reg;
    assign result        = result_reg;

endmodule

// ===== hdl/cnas_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnas_ctrl
// Sequencer that walks the mesh for the right-hand side, the forward sweep
// and the back sweep once per time step, and for the output once per run.
// ----------------------------------------------------------------------------
module cnas_ctrl #(
    parameter int MAX_POINTS = cnas_pkg::MAX_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cnas_pkg::cnas_kind_t    kind,
    input  logic [15:0]             step_count,
    input  cnas_pkg::cnas_status_t  stat,
    output cnas_pkg::cnas_cmd_t     cmd,
    output logic                    busy
);

    localparam int AW = $clog2(MAX_POINTS);

    cnas_pkg::cnas_state_t state_reg, state_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [15:0]    steps_reg, steps_next;
    logic [AW-1:0]  last_idx, nx, pv;
    logic           at_last, run_start;

    assign last_idx  = stat.last_idx[AW-1:0];
    assign at_last   = (idx_reg == last_idx);
    assign nx        = at_last ? '0 : idx_reg + 1'b1;
    assign pv        = (idx_reg == '0) ? last_idx : idx_reg - 1'b1;
    assign run_start = start && (kind == cnas_pkg::KIND_RUN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cnas_pkg::ST_IDLE:
                if (run_start) begin
                    state_next = (step_count == '0) ? cnas_pkg::ST_O_A : cnas_pkg::ST_R_A;
                end
            cnas_pkg::ST_R_A:    state_next = cnas_pkg::ST_R_B;
            cnas_pkg::ST_R_B:    state_next = cnas_pkg::ST_R_C;
            cnas_pkg::ST_R_C:    state_next = cnas_pkg::ST_R_D;
            cnas_pkg::ST_R_D:    state_next = cnas_pkg::ST_R_E;
            cnas_pkg::ST_R_E:    state_next = at_last ? cnas_pkg::ST_FI_A : cnas_pkg::ST_R_A;
            cnas_pkg::ST_FI_A:   state_next = cnas_pkg::ST_FI_B;
            cnas_pkg::ST_FI_B:   state_next = cnas_pkg::ST_F_A;
            cnas_pkg::ST_F_A:    state_next = cnas_pkg::ST_F_B;
            cnas_pkg::ST_F_B:    state_next = cnas_pkg::ST_F_C;
            cnas_pkg::ST_F_C:    state_next = cnas_pkg::ST_F_D;
            cnas_pkg::ST_F_D:
                if (stat.div_done) begin
                    state_next = cnas_pkg::ST_F_E;
                end
            cnas_pkg::ST_F_E:
                if (stat.div_done) begin
                    state_next = at_last ? cnas_pkg::ST_B_INIT : cnas_pkg::ST_F_A;
                end
            cnas_pkg::ST_B_INIT: state_next = cnas_pkg::ST_B_A;
            cnas_pkg::ST_B_A:    state_next = cnas_pkg::ST_B_B;
            cnas_pkg::ST_B_B:    state_next = cnas_pkg::ST_B_C;
            cnas_pkg::ST_B_C:
                if (idx_reg == '0) begin
                    state_next = (steps_reg == 16'd1) ? cnas_pkg::ST_O_A : cnas_pkg::ST_R_A;
                end else begin
                    state_next = cnas_pkg::ST_B_A;
                end
            cnas_pkg::ST_O_A:    state_next = cnas_pkg::ST_O_B;
            cnas_pkg::ST_O_B:    state_next = at_last ? cnas_pkg::ST_IDLE : cnas_pkg::ST_O_A;
            default:             state_next = cnas_pkg::ST_IDLE;
        endcase
    end

    // Point index and remaining step count.
    always_comb
    begin
        idx_next   = idx_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            cnas_pkg::ST_IDLE:
                if (run_start) begin
                    idx_next   = '0;
                    steps_next = step_count;
                end
            cnas_pkg::ST_R_E:  idx_next = nx;
            cnas_pkg::ST_FI_B: idx_next = AW'(1);
            cnas_pkg::ST_F_E:
                if (stat.div_done && !at_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            cnas_pkg::ST_B_INIT: idx_next = last_idx - 1'b1;
            cnas_pkg::ST_B_C:
                if (idx_reg == '0) begin
                    steps_next = steps_reg - 16'd1;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            cnas_pkg::ST_O_B: idx_next = nx;
            default: ;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.op   = cnas_pkg::OP_NONE;
        cmd.addr = cnas_pkg::POINT_W'(idx_reg);
        cmd.last = 1'b0;
        unique case (state_reg)
            cnas_pkg::ST_R_A:    cmd.addr = cnas_pkg::POINT_W'(nx);
            cnas_pkg::ST_R_B:
            begin
                cmd.op   = cnas_pkg::OP_CAP_NEXT;
                cmd.addr = cnas_pkg::POINT_W'(pv);
            end
            cnas_pkg::ST_R_C:    cmd.op = cnas_pkg::OP_CAP_DIFF;
            cnas_pkg::ST_R_D:    cmd.op = cnas_pkg::OP_MUL_DIFF;
            cnas_pkg::ST_R_E:    cmd.op = cnas_pkg::OP_WR_Q;
            cnas_pkg::ST_FI_A:   cmd.addr = '0;
            cnas_pkg::ST_FI_B:
            begin
                cmd.op   = cnas_pkg::OP_FWD_INIT;
                cmd.addr = '0;
            end
            cnas_pkg::ST_F_A:    cmd.op = cnas_pkg::OP_FWD_MUL_C;
            cnas_pkg::ST_F_B:    cmd.op = cnas_pkg::OP_FWD_PIVOT;
            cnas_pkg::ST_F_C:    cmd.op = cnas_pkg::OP_FWD_NUM;
            cnas_pkg::ST_F_D:    cmd.op = cnas_pkg::OP_FWD_WR_C;
            cnas_pkg::ST_F_E:    cmd.op = cnas_pkg::OP_FWD_WR_D;
            cnas_pkg::ST_B_INIT:
            begin
                cmd.op   = cnas_pkg::OP_BK_INIT;
                cmd.addr = cnas_pkg::POINT_W'(last_idx);
            end
            cnas_pkg::ST_B_B:    cmd.op = cnas_pkg::OP_BK_MUL;
            cnas_pkg::ST_B_C:    cmd.op = cnas_pkg::OP_BK_WR;
            cnas_pkg::ST_O_B:
            begin
                cmd.op   = cnas_pkg::OP_OUT_EMIT;
                cmd.last = at_last;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != cnas_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= cnas_pkg::ST_IDLE;
            idx_reg   <= '0;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            steps_reg <= steps_next;
        end
    end

endmodule

// ===== hdl/crank_nicolson_advection_step_top.sv =====
// ----------------------------------------------------------------------------
// crank_nicolson_advection_step_top
// Crank-Nicolson linear advection on a periodic mesh, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A transaction on the command channel is taken when start is high and busy
// is low. A load transaction (kind 0) writes one initial sample in that cycle
// and never raises busy, so loads can follow one per cycle. A run transaction
// (kind 1) raises busy, performs step_count time steps and then emits one
// result per mesh point on result, each marked by strobe for one cycle, with
// last set on the final point; busy drops in the cycle of that final strobe.
// Each time step walks the mesh for the right-hand side, the forward sweep
// and the back sweep; the two divides per point of the forward sweep
// through the one-bit-per-cycle divider take the largest share of a step.
// The output pass follows the last time step. Configuration writes
// (wr_en, wr_index, wr_data) are registered; the user must make them while
// busy is low, which the block itself does not enforce. Reset returns c to
// 0 and the mesh to MAX_POINTS points; the memories hold no defined value
// until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crank_nicolson_advection_step_top #(
    parameter int MAX_POINTS = cnas_pkg::MAX_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  cnas_pkg::cnas_item_t    item,
    output logic                    strobe,
    output cnas_pkg::cnas_result_t  result,
    input  logic                    wr_en,
    input  cnas_pkg::cnas_cfg_t     wr_index,
    input  logic [31:0]             wr_data
);

    cnas_pkg::cnas_cmd_t    cmd;
    cnas_pkg::cnas_status_t stat;
    logic                   load;

    // A load transaction writes the wave store directly.
    assign load = start && !busy && (item.kind == cnas_pkg::KIND_LOAD);

    cnas_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !busy),
        .kind       (item.kind),
        .step_count (item.step_count),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    cnas_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .item     (item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .stat     (stat),
        .strobe   (strobe),
        .result   (result)
    );

    // Results appear only as the tail of a run.
    `CNAS_ASSERT(a_strobe_in_run, strobe |-> $past(busy))
    // The final result ends the run in the same cycle.
    `CNAS_ASSERT(a_fell_on_last, $fell(busy) |-> (strobe && result.last))
    // No result directly follows the final one.
    `CNAS_ASSERT(a_gap_after_last, (strobe && result.last) |=> !strobe)

endmodule
